### sv/ffa_pkg.sv
// Shared types and constants of the first-fit allocator.
package ffa_pkg;

    localparam int MEM_BYTES    = 16384;
    localparam int HEADER_BYTES = 32;
    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int OFF_W        = 14;
    localparam int LEN_W        = 15;

    localparam logic [LEN_W:0] TWO_HEADERS = (LEN_W+1)'(2 * HEADER_BYTES);
    localparam logic [LEN_W:0] HDR        = (LEN_W+1)'(HEADER_BYTES);

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TOO_LITTLE = 3'd1,
        ST_NO_FIT     = 3'd2,
        ST_UNKNOWN    = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic             used;
    } t_entry;

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_IDLE, S_START, S_SCAN_RD, S_SCAN_EV,
        S_UP_INIT, S_UP_CHK, S_UP_RD, S_UP_WR, S_WR_A, S_WR_B,
        S_NXT_RD, S_NXT_EV, S_REL_WR, S_DN_CHK, S_DN_RD, S_DN_WR,
        S_DN_END, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_INIT0, OP_INIT1, OP_LOAD, OP_START, OP_SCAN_RD,
        OP_SCAN_EV, OP_UP_INIT, OP_UP_RD, OP_UP_WR, OP_WR_A, OP_WR_B,
        OP_NXT_RD, OP_NXT_EV, OP_REL_WR, OP_DN_RD, OP_DN_WR, OP_DN_END,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic func;
        logic too_little;
        logic match;
        logic last;
        logic full;
        logic up_more;
        logic dn_more;
        logic out_busy;
    } t_dp_stat;

endpackage

### sv/first_fit_allocator_core.sv
// Top level of the first-fit segment allocator.
// One request at a time: the table of up to 64 segments is scanned entry by entry, in a read
// and an evaluate state, and shifted entry by entry, in a check, a read and a write state,
// through a table memory with one write port and a registered read port; a release rewrites
// every entry above the hit even when nothing merges. The INIT0 and INIT1 states after reset
// seed the table before the first transfer.
// A finished result waits in an output register while the next request is taken.
module first_fit_allocator_core
    import ffa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // request_size[14:0], release_address[28:15]
    input  logic        i_s_axis_tuser,  // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // status[2:0], payload_address[16:3], free_bytes[31:17]
);

    t_op      op;
    t_dp_stat stat;

    ffa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_stat          (stat),
        .o_s_axis_tready (o_s_axis_tready),
        .o_op            (op)
    );

    ffa_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tready (i_m_axis_tready),
        .o_stat          (stat),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

### sv/ffa_datapath.sv
// Segment table memory, request registers and result register.
module ffa_datapath
    import ffa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  logic [31:0] i_s_axis_tdata,  // request_size[14:0], release_address[28:15]
    input  logic        i_s_axis_tuser,  // func
    input  logic        i_m_axis_tready,
    output t_dp_stat    o_stat,
    output logic        o_m_axis_tvalid,
    output logic [31:0] o_m_axis_tdata   // status[2:0], payload_address[16:3], free_bytes[31:17]
);

    t_entry r_mem [MAX_SEGMENTS];
    t_entry r_rdata;

    logic             r_func;
    logic [LEN_W-1:0] r_size;
    logic [OFF_W-1:0] r_addr;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_free, n_free;
    t_entry           r_prev, r_cur, r_nxt;
    logic [IDX_W-1:0] r_hit;
    logic             r_next_free;
    logic [1:0]       r_rm;
    t_status          r_status;
    logic [OFF_W-1:0] r_paddr;
    logic             r_ovalid;
    logic [31:0]      r_odata;

    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             wr_en;
    t_entry           wr_data;
    logic [LEN_W:0]   need_len, used_len, rel_len, rel_free;
    logic             scan_match, prev_free;
    logic [IDX_W-1:0] rel_w;

    assign need_len  = {1'b0, r_size} + TWO_HEADERS;
    assign used_len  = {1'b0, r_size} + HDR;
    assign prev_free = !r_prev.used;
    assign rel_w     = prev_free ? r_hit - IDX_W'(1) : r_hit;
    assign rel_len   = {1'b0, r_cur.len}
                     + (r_next_free ? {1'b0, r_nxt.len} : '0)
                     + (prev_free ? {1'b0, r_prev.len} : '0);
    assign rel_free  = {1'b0, r_free} + {1'b0, r_cur.len} - HDR
                     + (prev_free ? HDR : '0) + (r_next_free ? HDR : '0);

    always_comb begin
        if (r_idx == '0) begin
            scan_match = 1'b0;
        end else if (r_func) begin
            scan_match = r_rdata.used && (r_rdata.off + OFF_W'(HEADER_BYTES) == r_addr);
        end else begin
            scan_match = !r_rdata.used && ({1'b0, r_rdata.len} >= need_len);
        end
    end

    always_comb begin
        o_stat.func       = r_func;
        o_stat.too_little = !r_func && (r_size > r_free);
        o_stat.match      = scan_match;
        o_stat.last       = (r_idx + CNT_W'(1)) == r_count;
        o_stat.full       = r_count >= CNT_W'(MAX_SEGMENTS);
        o_stat.up_more    = r_idx > ({1'b0, r_hit} + CNT_W'(1));
        o_stat.dn_more    = (r_idx + CNT_W'(r_rm)) < r_count;
        o_stat.out_busy   = r_ovalid && !i_m_axis_tready;
    end

    always_comb begin
        case (i_op)
            OP_UP_RD:  rd_addr = r_idx[IDX_W-1:0] - IDX_W'(1);
            OP_NXT_RD: rd_addr = r_hit + IDX_W'(1);
            OP_DN_RD:  rd_addr = r_idx[IDX_W-1:0] + IDX_W'(r_rm);
            default:   rd_addr = r_idx[IDX_W-1:0];
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_idx[IDX_W-1:0];
        wr_data = r_rdata;
        case (i_op)
            OP_INIT0: begin
                wr_addr = '0;
                wr_data = '{off: '0, len: LEN_W'(HEADER_BYTES), used: 1'b1};
            end
            OP_INIT1: begin
                wr_addr = IDX_W'(1);
                wr_data = '{off: OFF_W'(HEADER_BYTES),
                            len: LEN_W'(MEM_BYTES - HEADER_BYTES), used: 1'b0};
            end
            OP_UP_WR, OP_DN_WR: begin
            end
            OP_WR_A: begin
                wr_addr = r_hit + IDX_W'(1);
                wr_data = '{off: r_cur.off + used_len[OFF_W-1:0],
                            len: r_cur.len - used_len[LEN_W-1:0], used: 1'b0};
            end
            OP_WR_B: begin
                wr_addr = r_hit;
                wr_data = '{off: r_cur.off, len: used_len[LEN_W-1:0], used: 1'b1};
            end
            OP_REL_WR: begin
                wr_addr = rel_w;
                wr_data = '{off: prev_free ? r_prev.off : r_cur.off,
                            len: rel_len[LEN_W-1:0], used: 1'b0};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_comb begin
        n_count = r_count;
        n_free  = r_free;
        case (i_op)
            OP_WR_B: begin
                n_count = r_count + CNT_W'(1);
                n_free  = r_free - used_len[LEN_W-1:0];
            end
            OP_REL_WR: n_free  = rel_free[LEN_W-1:0];
            OP_DN_END: n_count = r_count - CNT_W'(r_rm);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= CNT_W'(2);
            r_free   <= LEN_W'(MEM_BYTES - 2 * HEADER_BYTES);
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_free  <= n_free;
            if (i_op == OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_func   <= i_s_axis_tuser;
                r_size   <= i_s_axis_tdata[LEN_W-1:0];
                r_addr   <= i_s_axis_tdata[LEN_W+OFF_W-1:LEN_W];
                r_idx    <= '0;
                r_status <= ST_OK;
                r_paddr  <= '0;
            end
            OP_START: begin
                if (o_stat.too_little) begin
                    r_status <= ST_TOO_LITTLE;
                end
            end
            OP_SCAN_EV: begin
                if (scan_match) begin
                    r_cur <= r_rdata;
                    r_hit <= r_idx[IDX_W-1:0];
                    if (!r_func && o_stat.full) begin
                        r_status <= ST_FULL;
                    end
                end else begin
                    r_prev <= r_rdata;
                    r_idx  <= r_idx + CNT_W'(1);
                    if (o_stat.last) begin
                        r_status <= r_func ? ST_UNKNOWN : ST_NO_FIT;
                    end
                end
            end
            OP_UP_INIT: r_idx <= r_count;
            OP_UP_WR:   r_idx <= r_idx - CNT_W'(1);
            OP_WR_B:    r_paddr <= r_cur.off + OFF_W'(HEADER_BYTES);
            OP_NXT_EV: begin
                r_nxt       <= r_rdata;
                r_next_free <= (({1'b0, r_hit} + CNT_W'(1)) < r_count) && !r_rdata.used;
            end
            OP_REL_WR: begin
                r_idx <= {1'b0, rel_w} + CNT_W'(1);
                r_rm  <= {1'b0, prev_free} + {1'b0, r_next_free};
            end
            OP_DN_WR: r_idx <= r_idx + CNT_W'(1);
            OP_EMIT:  r_odata <= {r_free, r_paddr, r_status};
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= CNT_W'(2) && r_count <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count out of range");

    a_split_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == OP_WR_B |-> r_count < CNT_W'(MAX_SEGMENTS))
        else $error("split with full table");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == OP_EMIT |-> !(r_ovalid && !i_m_axis_tready))
        else $error("result overwritten before transfer");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= LEN_W'(MEM_BYTES - 2 * HEADER_BYTES))
        else $error("free byte count exceeds store");

endmodule

### sv/ffa_ctrl.sv
// Sequencer that steps the segment table through scan, split and merge.
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_axis_tvalid,
    input  t_dp_stat i_stat,
    output logic     o_s_axis_tready,
    output t_op      o_op
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT0;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT0:   n_state = S_INIT1;
            S_INIT1:   n_state = S_IDLE;
            S_IDLE:    if (i_s_axis_tvalid) n_state = S_START;
            S_START:   n_state = i_stat.too_little ? S_DONE : S_SCAN_RD;
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV: begin
                if (i_stat.match) begin
                    if (i_stat.func) begin
                        n_state = S_NXT_RD;
                    end else begin
                        n_state = i_stat.full ? S_DONE : S_UP_INIT;
                    end
                end else begin
                    n_state = i_stat.last ? S_DONE : S_SCAN_RD;
                end
            end
            S_UP_INIT: n_state = S_UP_CHK;
            S_UP_CHK:  n_state = i_stat.up_more ? S_UP_RD : S_WR_A;
            S_UP_RD:   n_state = S_UP_WR;
            S_UP_WR:   n_state = S_UP_CHK;
            S_WR_A:    n_state = S_WR_B;
            S_WR_B:    n_state = S_DONE;
            S_NXT_RD:  n_state = S_NXT_EV;
            S_NXT_EV:  n_state = S_REL_WR;
            S_REL_WR:  n_state = S_DN_CHK;
            S_DN_CHK:  n_state = i_stat.dn_more ? S_DN_RD : S_DN_END;
            S_DN_RD:   n_state = S_DN_WR;
            S_DN_WR:   n_state = S_DN_CHK;
            S_DN_END:  n_state = S_DONE;
            S_DONE:    if (!i_stat.out_busy) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        o_op            = OP_NONE;
        case (r_state)
            S_INIT0:   o_op = OP_INIT0;
            S_INIT1:   o_op = OP_INIT1;
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) o_op = OP_LOAD;
            end
            S_START:   o_op = OP_START;
            S_SCAN_RD: o_op = OP_SCAN_RD;
            S_SCAN_EV: o_op = OP_SCAN_EV;
            S_UP_INIT: o_op = OP_UP_INIT;
            S_UP_RD:   o_op = OP_UP_RD;
            S_UP_WR:   o_op = OP_UP_WR;
            S_WR_A:    o_op = OP_WR_A;
            S_WR_B:    o_op = OP_WR_B;
            S_NXT_RD:  o_op = OP_NXT_RD;
            S_NXT_EV:  o_op = OP_NXT_EV;
            S_REL_WR:  o_op = OP_REL_WR;
            S_DN_RD:   o_op = OP_DN_RD;
            S_DN_WR:   o_op = OP_DN_WR;
            S_DN_END:  o_op = OP_DN_END;
            S_DONE:    if (!i_stat.out_busy) o_op = OP_EMIT;
            default:   o_op = OP_NONE;
        endcase
    end

endmodule

### verif/first_fit_allocator_checker.sv
// Checker for the first-fit allocator: segment table prediction and result comparison.
module first_fit_allocator_checker
    import ffa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,
    input  logic        i_s_axis_tuser,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [31:0] i_m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        t_status          status;
        logic [OFF_W-1:0] paddr;
        logic [LEN_W-1:0] free_bytes;
    } t_grant;

    int unsigned seg_start [MAX_SEGMENTS];
    int unsigned seg_size  [MAX_SEGMENTS];
    bit          seg_taken [MAX_SEGMENTS];
    int unsigned seg_total;
    t_grant      grant_queue[$];

    function automatic int unsigned free_payload();
        int unsigned sum;
        sum = 0;
        for (int i = 0; i < seg_total; i++)
            if (!seg_taken[i]) sum += seg_size[i] - HEADER_BYTES;
        return sum;
    endfunction

    function automatic void drop_segment(int unsigned idx);
        for (int k = idx; k + 1 < seg_total; k++) begin
            seg_start[k] = seg_start[k+1];
            seg_size[k]  = seg_size[k+1];
            seg_taken[k] = seg_taken[k+1];
        end
        seg_total--;
    endfunction

    function automatic t_grant serve_request(logic func, int unsigned want, int unsigned where);
        t_grant g;
        int     hit;
        int unsigned used_len;
        g.status = ST_OK;
        g.paddr  = '0;
        hit = -1;
        if (!func) begin
            if (want > free_payload()) begin
                g.status = ST_TOO_LITTLE;
            end else begin
                for (int i = 1; i < seg_total; i++)
                    if (hit < 0 && !seg_taken[i] && seg_size[i] >= want + 2 * HEADER_BYTES)
                        hit = i;
                if (hit < 0) begin
                    g.status = ST_NO_FIT;
                end else if (seg_total >= MAX_SEGMENTS) begin
                    g.status = ST_FULL;
                end else begin
                    used_len = want + HEADER_BYTES;
                    for (int k = seg_total; k > hit + 1; k--) begin
                        seg_start[k] = seg_start[k-1];
                        seg_size[k]  = seg_size[k-1];
                        seg_taken[k] = seg_taken[k-1];
                    end
                    seg_start[hit+1] = seg_start[hit] + used_len;
                    seg_size[hit+1]  = seg_size[hit] - used_len;
                    seg_taken[hit+1] = 0;
                    seg_size[hit]    = used_len;
                    seg_taken[hit]   = 1;
                    seg_total++;
                    g.paddr = OFF_W'(seg_start[hit] + HEADER_BYTES);
                end
            end
        end else begin
            for (int i = 1; i < seg_total; i++)
                if (hit < 0 && seg_taken[i] &&
                    ((seg_start[i] + HEADER_BYTES) & 32'h3fff) == where)
                    hit = i;
            if (hit < 0) begin
                g.status = ST_UNKNOWN;
            end else begin
                seg_taken[hit] = 0;
                if (hit + 1 < seg_total && !seg_taken[hit+1]) begin
                    seg_size[hit] += seg_size[hit+1];
                    drop_segment(hit + 1);
                end
                if (!seg_taken[hit-1]) begin
                    seg_size[hit-1] += seg_size[hit];
                    drop_segment(hit);
                end
            end
        end
        g.free_bytes = LEN_W'(free_payload());
        return g;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        seg_total = 2;
        seg_start[0] = 0;            seg_size[0] = HEADER_BYTES;             seg_taken[0] = 1;
        seg_start[1] = HEADER_BYTES; seg_size[1] = MEM_BYTES - HEADER_BYTES; seg_taken[1] = 0;
    end

    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && i_s_axis_tvalid && i_s_axis_tready)
            grant_queue.push_back(serve_request(i_s_axis_tuser, 32'(i_s_axis_tdata[14:0]),
                                                32'(i_s_axis_tdata[28:15])));
        if (i_rst_n && i_m_axis_tvalid && i_m_axis_tready) begin
            if (grant_queue.size() == 0) begin
                report_mismatch("unexpected transfer", i_m_axis_tdata, 0);
            end else begin
                g = grant_queue.pop_front();
                if (i_m_axis_tdata[2:0] !== g.status)
                    report_mismatch("status", 32'(i_m_axis_tdata[2:0]), 32'(g.status));
                if (i_m_axis_tdata[16:3] !== g.paddr)
                    report_mismatch("payload_address", 32'(i_m_axis_tdata[16:3]),
                                    32'(g.paddr));
                if (i_m_axis_tdata[31:17] !== g.free_bytes)
                    report_mismatch("free_bytes", 32'(i_m_axis_tdata[31:17]),
                                    32'(g.free_bytes));
            end
        end
        o_pending <= grant_queue.size();
    end

endmodule

### verif/testbench.sv
// Testbench top: request stimulus, receiver stalls and verdict for the allocator.
module testbench;
    import ffa_pkg::*;

    localparam logic FN_ALLOC   = 1'b0;
    localparam logic FN_RELEASE = 1'b1;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 19;
    int          recv_idle_pct = 68;
    bit          hold_off = 0;
    bit          hold_start = 0;
    int unsigned granted[$];

    always #10 i_clk = ~i_clk;

    first_fit_allocator_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata)
    );

    first_fit_allocator_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    // collect granted addresses so releases mostly hit live segments
    always @(posedge i_clk)
        if (m_tvalid && m_tready && m_tdata[2:0] == ST_OK && m_tdata[16:3] != 0)
            granted.push_back(32'(m_tdata[16:3]));

    always @(posedge i_clk)
        m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

    task automatic send_request(logic func, logic [14:0] want, logic [13:0] where);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tuser  <= func;
        s_tdata  <= {3'b0, where, want};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic random_request();
        int unsigned pick;
        int unsigned idx;
        pick = $urandom_range(99);
        if (pick < 45) begin
            send_request(FN_ALLOC, (pick < 40) ? 15'($urandom_range(400)) : 15'($urandom),
                         14'($urandom));
        end else if (pick < 90 && granted.size() > 0) begin
            idx = $urandom_range(granted.size() - 1);
            send_request(FN_RELEASE, 15'($urandom), 14'(granted[idx]));
            granted.delete(idx);
        end else begin
            send_request(FN_RELEASE, 15'($urandom), 14'($urandom));
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_request(FN_ALLOC, 15'd16384, 14'h3fff);
        send_request(FN_ALLOC, 15'h7fff, 14'd0);
        send_request(FN_ALLOC, 15'd16353, 14'd0);
        send_request(FN_ALLOC, 15'd0, 14'd0);
        send_request(FN_ALLOC, 15'd100, 14'd0);
        send_request(FN_RELEASE, 15'd0, 14'd0);
        send_request(FN_RELEASE, 15'h7fff, 14'd32);
        send_request(FN_RELEASE, 15'd0, 14'd32);
        send_request(FN_RELEASE, 15'd0, 14'h3fff);
        send_request(FN_RELEASE, 15'd0, 14'd64);
        send_request(FN_ALLOC, 15'd16288, 14'd0);
        send_request(FN_ALLOC, 15'd16287, 14'd0);
        send_request(FN_ALLOC, 15'd1, 14'd0);
        // fill the table to its last entry, then hit the full case
        for (int i = 0; i < 66; i++) send_request(FN_ALLOC, 15'd8, 14'd0);
        for (int i = 0; i < 70; i++) begin
            if (i == 20) begin
                hold_start = 1;
                send_idle_pct = 0;
            end
            send_request(FN_RELEASE, 15'd0, 14'd261 + 14'(i) * 14'd40);
        end
        send_idle_pct = 19;
        granted.delete();
        send_request(FN_RELEASE, 15'd0, 14'd32);
        for (int i = 0; i < 90; i++) random_request();
        send_idle_pct = 68;
        recv_idle_pct = 19;
        for (int i = 0; i < 80; i++) random_request();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 80; i++) random_request();
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // receiver hold-off, started partway through the release run
    initial begin
        wait (hold_start);
        hold_off <= 1;
        repeat (2000) @(posedge i_clk);
        hold_off <= 0;
    end

    initial begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### first_fit_allocator_core.f
sv/ffa_pkg.sv
sv/ffa_datapath.sv
sv/ffa_ctrl.sv
sv/first_fit_allocator_core.sv
verif/first_fit_allocator_checker.sv
verif/testbench.sv
